// File: src/oavs_pkg.sv
// Shared types and constants for the obstacle-avoid velocity shaper.
// No dependencies; every other file of the block but oavs_if imports this package.
`default_nettype none
package oavs_pkg;

  localparam logic [15:0] Q_PI      = 16'd12868;
  localparam logic [15:0] Q_HALF_PI = 16'd6434;
  localparam logic [29:0] Q28_ONE   = 30'h1000_0000;
  localparam logic [24:0] T_SAT     = 25'h100_0000;

  localparam int HORNER_STEPS = 5;
  localparam int HORNER_K [HORNER_STEPS] = '{90, 56, 30, 12, 2};
  localparam int DIV_BITS = 25;

  localparam logic [1:0] ZONE_CLEAR   = 2'd0;
  localparam logic [1:0] ZONE_CAUTION = 2'd1;
  localparam logic [1:0] ZONE_DANGER  = 2'd2;

  localparam logic [3:0] REG_SAFE_DIST    = 4'd0;
  localparam logic [3:0] REG_DANGER_DIST  = 4'd1;
  localparam logic [3:0] REG_LINEAR_GAIN  = 4'd2;
  localparam logic [3:0] REG_TURN_GAIN    = 4'd3;
  localparam logic [3:0] REG_LINEAR_LIMIT = 4'd4;
  localparam logic [3:0] REG_LINEAR_DB    = 4'd5;
  localparam logic [3:0] REG_ANGULAR_LIM  = 4'd6;
  localparam logic [3:0] REG_ANGULAR_DB   = 4'd7;

  // Per-item data that rides alongside the cosine and divide stages.
  typedef struct packed {
    logic [15:0]        distance;
    logic               mneg;   // mirrored bearing negative: flip turn gain
    logic               cneg;   // cosine negative
    logic               czero;  // cosine rounded to zero
    logic signed [15:0] rl;
    logic signed [15:0] ra;
  } side_t;

  typedef struct packed {
    logic [29:0] u2;
    logic [28:0] c;
    side_t       side;
  } hdata_t;

  typedef struct packed {
    logic [15:0] safe_dist;
    logic [15:0] danger_dist;
    logic [15:0] linear_gain;
    logic [15:0] turn_gain;
    logic [14:0] linear_limit;
    logic [14:0] linear_db;
    logic [14:0] angular_limit;
    logic [14:0] angular_db;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/oavs_if.sv
// Valid/ready channel interfaces for input samples and shaped commands.
// Depends on nothing.
`default_nettype none
interface oavs_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] obstacle_distance;
  logic signed [14:0] obstacle_bearing;
  logic signed [15:0] raw_linear;
  logic signed [15:0] raw_angular;
  modport source (output valid, obstacle_distance, obstacle_bearing, raw_linear,
                  raw_angular, input ready);
  modport sink (input valid, obstacle_distance, obstacle_bearing, raw_linear,
                raw_angular, output ready);
endinterface

interface oavs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_linear;
  logic signed [15:0] out_angular;
  logic        [1:0]  zone;
  modport source (output valid, out_linear, out_angular, zone, input ready);
  modport sink (input valid, out_linear, out_angular, zone, output ready);
endinterface
`default_nettype wire

// File: src/oavs_horner_step.sv
// One Horner step of the cosine series: c = 1 - ((u2*c) >> 28) / K, clamped at 0.
// Three register stages; depends on oavs_pkg.
`default_nettype none
module oavs_horner_step
  import oavs_pkg::*;
#(
  parameter int K = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_vld,
  input  wire hdata_t in_dat,
  output logic        out_vld,
  output hdata_t      out_dat
);
  localparam logic [30:0] RECIP = 31'((64'd1 << 31) / K);

  logic        vld1, vld2;
  logic [29:0] p1, p2, qe2, u2_1, u2_2;
  side_t       sd1, sd2;
  logic [58:0] prod1;
  logic [60:0] prod2;
  logic [36:0] qk, rem;
  logic [29:0] q;

  // stage 1: series product
  assign prod1 = 59'(in_dat.u2) * 59'(in_dat.c);
  // stage 2: reciprocal multiply, estimate low by at most one
  assign prod2 = 61'(p1) * 61'(RECIP);
  // stage 3: correct the estimate and subtract from one
  assign qk  = 37'(qe2) * 37'(K);
  assign rem = 37'(p2) - qk;
  assign q   = (rem >= 37'(K)) ? 30'(qe2 + 30'd1) : qe2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
    if (en) begin
      p1          <= prod1[57:28];
      u2_1        <= in_dat.u2;
      sd1         <= in_dat.side;
      p2          <= p1;
      qe2         <= prod2[60:31];
      u2_2        <= u2_1;
      sd2         <= sd1;
      out_dat.u2  <= u2_2;
      out_dat.side <= sd2;
      out_dat.c   <= (q >= Q28_ONE) ? 29'd0 : 29'(Q28_ONE - q);
    end
  end
endmodule
`default_nettype wire

// File: src/oavs_divider.sv
// Pipelined restoring divider, one quotient bit per stage, numerator 25 bits.
// Divisor is the obstacle distance carried in the side data; depends on oavs_pkg.
`default_nettype none
module oavs_divider
  import oavs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [24:0] num,
  input  wire side_t       in_side,
  output logic             out_vld,
  output logic [24:0]      quo,
  output side_t            out_side
);
  logic        vld [DIV_BITS];
  logic [15:0] rem [DIV_BITS];
  logic [24:0] nq  [DIV_BITS];
  side_t       sd  [DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_stg
    logic        vld_in;
    logic [15:0] rem_in;
    logic [24:0] nq_in;
    side_t       sd_in;
    logic [16:0] sh, diff;
    logic        ge;

    if (j == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = 16'd0;
      assign nq_in  = num;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign vld_in = vld[j-1];
      assign rem_in = rem[j-1];
      assign nq_in  = nq[j-1];
      assign sd_in  = sd[j-1];
    end

    assign sh   = {rem_in, nq_in[24]};
    assign ge   = sh >= {1'b0, sd_in.distance};
    assign diff = sh - {1'b0, sd_in.distance};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
      if (en) begin
        rem[j] <= ge ? diff[15:0] : sh[15:0];
        nq[j]  <= {nq_in[23:0], ge};
        sd[j]  <= sd_in;
      end
    end
  end

  assign out_vld  = vld[DIV_BITS-1];
  assign quo      = nq[DIV_BITS-1];
  assign out_side = sd[DIV_BITS-1];
endmodule
`default_nettype wire

// File: src/oavs_blend.sv
// Gain products, zone selection and clamp/deadband; the last stage is the output register.
// Depends on oavs_pkg.
`default_nettype none
module oavs_blend
  import oavs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire cfg_t        cfg,
  input  wire logic        in_vld,
  input  wire logic [24:0] quo,
  input  wire side_t       in_side,
  output logic             out_vld,
  output logic [15:0]      out_lin,
  output logic [15:0]      out_ang,
  output logic [1:0]       out_zone
);
  function automatic logic [15:0] shape(logic signed [31:0] v, logic [14:0] lim,
                                        logic [14:0] db);
    logic signed [31:0] sl, w, a;
    sl = $signed({17'd0, lim});
    if (v > sl) w = sl;
    else if (v < -sl) w = -sl;
    else w = v;
    a = (w < 0) ? -w : w;
    if (a < $signed({17'd0, db})) w = 32'sd0;
    return w[15:0];
  endfunction

  logic [24:0] tmag;
  logic [40:0] lprod, aprod;
  logic [1:0]  zone0;

  logic               vld1, vld2;
  logic [28:0]        lmag1, amag1;
  logic               lneg1, aneg1;
  logic [1:0]         zone1, zone2;
  logic signed [15:0] rl1, ra1;
  logic signed [31:0] lterm, aterm, lin_next, ang_next, lin2, ang2;

  // saturate on zero distance, unless the cosine rounded to zero
  always_comb begin
    if (in_side.distance == 16'd0) tmag = in_side.czero ? 25'd0 : T_SAT;
    else tmag = quo;
  end
  assign lprod = 41'(cfg.linear_gain) * 41'(tmag);
  assign aprod = 41'(cfg.turn_gain) * 41'(tmag);

  always_comb begin
    if (in_side.distance < cfg.safe_dist && in_side.distance > cfg.danger_dist)
      zone0 = ZONE_CAUTION;
    else if (in_side.distance < cfg.danger_dist) zone0 = ZONE_DANGER;
    else zone0 = ZONE_CLEAR;
  end

  assign lterm = lneg1 ? -$signed({3'd0, lmag1}) : $signed({3'd0, lmag1});
  assign aterm = aneg1 ? -$signed({3'd0, amag1}) : $signed({3'd0, amag1});

  always_comb begin
    case (zone1)
      ZONE_CAUTION: begin
        lin_next = {{16{rl1[15]}}, rl1} - lterm;
        ang_next = {{16{ra1[15]}}, ra1} + aterm;
      end
      ZONE_DANGER: begin
        lin_next = -lterm;
        ang_next = aterm;
      end
      default: begin
        lin_next = {{16{rl1[15]}}, rl1};
        ang_next = {{16{ra1[15]}}, ra1};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
    if (en) begin
      lmag1    <= lprod[40:12];
      amag1    <= aprod[40:12];
      lneg1    <= in_side.cneg;
      aneg1    <= in_side.cneg ^ in_side.mneg;
      zone1    <= zone0;
      rl1      <= in_side.rl;
      ra1      <= in_side.ra;
      lin2     <= lin_next;
      ang2     <= ang_next;
      zone2    <= zone1;
      out_lin  <= shape(lin2, cfg.linear_limit, cfg.linear_db);
      out_ang  <= shape(ang2, cfg.angular_limit, cfg.angular_db);
      out_zone <= zone2;
    end
  end
endmodule
`default_nettype wire

// File: src/obstacle_avoid_velocity_shaper_top.sv
// Obstacle-avoid velocity shaper. One transaction in gives one transaction out, in order,
// and a new transaction is accepted every cycle while the output is taken. The pipeline
// has one bearing-mirror stage, fifteen cosine stages (five Horner steps of
// three stages each), one rounding stage, 25 divider stages (one quotient bit each)
// and three stages of gain, zone blend and clamp, the last of which is the output
// register. All stages share one advance enable, so a stalled output holds the
// whole pipeline and the input. Configuration registers are written through
// cfg_write/cfg_index/cfg_data and must only change while the pipeline is empty;
// indexes beyond the register list are ignored. Depends on oavs_pkg, oavs_if,
// oavs_horner_step, oavs_divider and oavs_blend.
`default_nettype none
module obstacle_avoid_velocity_shaper_top
  import oavs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  oavs_in_if.sink          in_ch,
  oavs_out_if.source       out_ch,
  input  wire logic        cfg_write,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safe_dist     <= 16'd2048;
      cfg.danger_dist   <= 16'd819;
      cfg.linear_gain   <= 16'd819;
      cfg.turn_gain     <= 16'd1229;
      cfg.linear_limit  <= 15'd6144;
      cfg.linear_db     <= 15'd205;
      cfg.angular_limit <= 15'd6144;
      cfg.angular_db    <= 15'd205;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAFE_DIST:    cfg.safe_dist     <= cfg_data;
        REG_DANGER_DIST:  cfg.danger_dist   <= cfg_data;
        REG_LINEAR_GAIN:  cfg.linear_gain   <= cfg_data;
        REG_TURN_GAIN:    cfg.turn_gain     <= cfg_data;
        REG_LINEAR_LIMIT: cfg.linear_limit  <= cfg_data[14:0];
        REG_LINEAR_DB:    cfg.linear_db     <= cfg_data[14:0];
        REG_ANGULAR_LIM:  cfg.angular_limit <= cfg_data[14:0];
        REG_ANGULAR_DB:   cfg.angular_db    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Advance everything when the output register is empty or being drained.
  logic en;
  logic out_vld;
  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  // Front stage: mirror the bearing to the front and fold it into [0, pi/2].
  logic signed [15:0] bx, m;
  logic [15:0]        x, xc;
  logic               fold;
  logic [12:0]        u;
  logic [25:0]        usq;

  assign bx = {in_ch.obstacle_bearing[14], in_ch.obstacle_bearing};
  assign m  = (in_ch.obstacle_bearing > 15'sd0) ? $signed(Q_PI) - bx : -(bx + $signed(Q_PI));
  assign x  = m[15] ? 16'(-m) : 16'(m);
  assign xc = (x > Q_PI) ? Q_PI : x;
  assign fold = xc > Q_HALF_PI;
  assign u  = fold ? 13'(Q_PI - xc) : 13'(xc);
  assign usq = 26'(u) * 26'(u);

  logic   h_vld [HORNER_STEPS+1];
  hdata_t h_dat [HORNER_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld[0] <= 1'b0;
    end else if (en) begin
      h_vld[0] <= in_ch.valid;
    end
    if (en) begin
      h_dat[0].u2            <= {usq, 4'd0};
      h_dat[0].c             <= 29'(Q28_ONE);
      h_dat[0].side.distance <= in_ch.obstacle_distance;
      h_dat[0].side.mneg     <= m[15];
      h_dat[0].side.cneg     <= fold;
      h_dat[0].side.czero    <= 1'b0;
      h_dat[0].side.rl       <= in_ch.raw_linear;
      h_dat[0].side.ra       <= in_ch.raw_angular;
    end
  end

  // Cosine series, innermost coefficient first
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    oavs_horner_step #(.K(HORNER_K[i])) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (h_vld[i]),
      .in_dat  (h_dat[i]),
      .out_vld (h_vld[i+1]),
      .out_dat (h_dat[i+1])
    );
  end

  // Round the cosine to Q12 and form the numerator |cos| << 12.
  logic [29:0] c_round;
  logic [13:0] cmag;
  logic        rnd_vld;
  logic [24:0] rnd_num;
  side_t       rnd_side, rnd_side_next;

  assign c_round = 30'(h_dat[HORNER_STEPS].c) + 30'd32768;
  assign cmag    = c_round[29:16];

  // Flag a cosine that rounds to zero so zero distance does not saturate it.
  always_comb begin
    rnd_side_next       = h_dat[HORNER_STEPS].side;
    rnd_side_next.czero = (cmag == 14'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_vld <= 1'b0;
    end else if (en) begin
      rnd_vld <= h_vld[HORNER_STEPS];
    end
    if (en) begin
      rnd_num  <= {cmag[12:0], 12'd0};
      rnd_side <= rnd_side_next;
    end
  end

  logic        div_vld;
  logic [24:0] div_quo;
  side_t       div_side;

  oavs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (rnd_vld),
    .num      (rnd_num),
    .in_side  (rnd_side),
    .out_vld  (div_vld),
    .quo      (div_quo),
    .out_side (div_side)
  );

  logic [15:0] lin_q, ang_q;
  logic [1:0]  zone_q;

  oavs_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_vld   (div_vld),
    .quo      (div_quo),
    .in_side  (div_side),
    .out_vld  (out_vld),
    .out_lin  (lin_q),
    .out_ang  (ang_q),
    .out_zone (zone_q)
  );

  assign out_ch.valid       = out_vld;
  assign out_ch.out_linear  = lin_q;
  assign out_ch.out_angular = ang_q;
  assign out_ch.zone        = zone_q;

  // A held output must freeze the input side in the same cycle.
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid right after reset");

  // An accepted transaction lands in the front stage.
  a_front_capture: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> h_vld[0])
    else $error("accepted transaction not captured");
endmodule
`default_nettype wire

// File: bench/tb_obstacle_avoid_velocity_shaper_top.sv
// Self-checking bench for the obstacle-avoid velocity shaper: drives samples over
// the input channel, predicts each shaped command and checks the output channel.
// Depends on oavs_pkg, oavs_if and obstacle_avoid_velocity_shaper_top.
`default_nettype none
module tb_obstacle_avoid_velocity_shaper_top;
  import oavs_pkg::*;

  localparam int LATENCY = 45;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0]        distance;
    logic signed [14:0] bearing;
    logic signed [15:0] rl;
    logic signed [15:0] ra;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [1:0]         zone;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  oavs_in_if  in_ch();
  oavs_out_if out_ch();

  obstacle_avoid_velocity_shaper_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Testbench copy of the register file.
  cfg_t cfg;

  sample_t  pending_samples[$];
  command_t expected_commands[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;          // no idling on either side near the end
  bit in_taken = 1'b0;       // input transaction accepted at the last rising edge
  int src_gap = 0;
  int snk_gap = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cosine of a mirrored bearing in Q12, Taylor series in Q28.
  function automatic longint cos_q12(longint m);
    longint x, u, u2, c, p;
    bit neg;
    int ks[5];
    ks = '{90, 56, 30, 12, 2};
    x = m < 0 ? -m : m;
    neg = 1'b0;
    if (x > Q_PI) x = Q_PI;
    if (x > Q_HALF_PI) begin
      u = Q_PI - x;
      neg = 1'b1;
    end else begin
      u = x;
    end
    u = u * 65536;
    u2 = (u * u) >>> 28;
    c = 64'sd1 <<< 28;
    for (int i = 0; i < 5; i++) begin
      p = (u2 * c) >>> 28;
      c = (64'sd1 <<< 28) - p / ks[i];
      if (c < 0) c = 0;
    end
    c = (c + 32768) >>> 16;
    return neg ? -c : c;
  endfunction

  function automatic longint scale_by_gain(longint g, longint t);
    longint mag, p;
    mag = t < 0 ? -t : t;
    p = (g * mag) >>> 12;
    return t < 0 ? -p : p;
  endfunction

  function automatic longint clamp_deadband(longint v, longint lim, longint db);
    longint a;
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    a = v < 0 ? -v : v;
    if (a < db) v = 0;
    return v;
  endfunction

  function automatic command_t shape_command(sample_t s);
    command_t r;
    longint d, b, m, c, t, tg, lin, ang, mag;
    d = s.distance;
    b = s.bearing;
    m = (b > 0) ? (Q_PI - b) : -(b + Q_PI);
    c = cos_q12(m);
    if (d == 0) begin
      t = (c > 0) ? (64'sd1 <<< 24) : ((c < 0) ? -(64'sd1 <<< 24) : 0);
    end else begin
      mag = ((c < 0 ? -c : c) <<< 12) / d;
      t = c < 0 ? -mag : mag;
    end
    tg = scale_by_gain(cfg.turn_gain, t);
    if (m < 0) tg = -tg;
    if (d < cfg.safe_dist && d > cfg.danger_dist) begin
      r.zone = ZONE_CAUTION;
      lin = longint'(s.rl) - scale_by_gain(cfg.linear_gain, t);
      ang = longint'(s.ra) + tg;
    end else if (d < cfg.danger_dist) begin
      r.zone = ZONE_DANGER;
      lin = -scale_by_gain(cfg.linear_gain, t);
      ang = tg;
    end else begin
      r.zone = ZONE_CLEAR;
      lin = s.rl;
      ang = s.ra;
    end
    r.lin = 16'(clamp_deadband(lin, cfg.linear_limit, cfg.linear_db));
    r.ang = 16'(clamp_deadband(ang, cfg.angular_limit, cfg.angular_db));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  // Driver: present the head of the queue, advance on acceptance, insert idle bursts.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.obstacle_distance = '0;
    in_ch.obstacle_bearing = '0;
    in_ch.raw_linear = '0;
    in_ch.raw_angular = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(pending_samples.pop_front());
        if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
      end
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.obstacle_distance <= pending_samples[0].distance;
        in_ch.obstacle_bearing <= pending_samples[0].bearing;
        in_ch.raw_linear <= pending_samples[0].rl;
        in_ch.raw_angular <= pending_samples[0].ra;
      end else begin
        in_ch.valid <= 1'b0;
      end
      // Sink stalls come in bursts too.
      if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        expected_commands.push_back(shape_command(
          {in_ch.obstacle_distance, in_ch.obstacle_bearing, in_ch.raw_linear,
           in_ch.raw_angular}));
      end
      if (out_ch.valid && out_ch.ready) begin
        command_t exp_cmd;
        if (expected_commands.size() == 0) begin
          report_mismatch("output transaction with nothing expected");
        end else begin
          exp_cmd = expected_commands.pop_front();
          if (out_ch.out_linear !== exp_cmd.lin)
            report_mismatch($sformatf("out_linear %0d, expected %0d",
                                      out_ch.out_linear, exp_cmd.lin));
          if (out_ch.out_angular !== exp_cmd.ang)
            report_mismatch($sformatf("out_angular %0d, expected %0d",
                                      out_ch.out_angular, exp_cmd.ang));
          if (out_ch.zone !== exp_cmd.zone)
            report_mismatch($sformatf("zone %0d, expected %0d",
                                      out_ch.zone, exp_cmd.zone));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SAFE_DIST:    cfg.safe_dist = val;
      REG_DANGER_DIST:  cfg.danger_dist = val;
      REG_LINEAR_GAIN:  cfg.linear_gain = val;
      REG_TURN_GAIN:    cfg.turn_gain = val;
      REG_LINEAR_LIMIT: cfg.linear_limit = val[14:0];
      REG_LINEAR_DB:    cfg.linear_db = val[14:0];
      REG_ANGULAR_LIM:  cfg.angular_limit = val[14:0];
      REG_ANGULAR_DB:   cfg.angular_db = val[14:0];
      default: ;
    endcase
  endtask

  // Hold until every queued sample is accepted and every result has returned.
  task automatic drain();
    while (pending_samples.size() > 0 || expected_commands.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic sample_t random_sample(bit near_band);
    sample_t s;
    if (near_band) s.distance = 16'($urandom_range(0, 2 * (cfg.safe_dist + 64)));
    else s.distance = 16'($urandom);
    if ($urandom_range(0, 3) == 0) s.bearing = 15'($urandom);
    else s.bearing = 15'($signed($urandom_range(0, 2 * 12868)) - 12868);
    s.rl = 16'($urandom);
    s.ra = 16'($urandom);
    if ($urandom_range(0, 7) == 0) s.rl = 16'($signed($urandom_range(0, 400)) - 200);
    return s;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_samples.push_back(random_sample($urandom_range(0, 3) != 0));
  endtask

  initial begin
    cfg = '{safe_dist: 16'd2048, danger_dist: 16'd819, linear_gain: 16'd819,
            turn_gain: 16'd1229, linear_limit: 15'd6144, linear_db: 15'd205,
            angular_limit: 15'd6144, angular_db: 15'd205};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: thresholds, zero distance, zero and extreme bearings, extreme commands.
    pending_samples.push_back('{16'd0, 15'sd0, 16'sd1000, -16'sd1000});
    pending_samples.push_back('{16'd0, 15'sd6434, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'd0, 15'sd12868, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'd819, 15'sd100, 16'sd2000, 16'sd2000});
    pending_samples.push_back('{16'd2048, -15'sd100, 16'sd2000, 16'sd2000});
    pending_samples.push_back('{16'd820, -15'sd12868, 16'sd100, -16'sd100});
    pending_samples.push_back('{16'd2047, 15'sd3000, -16'sd32768, 16'sd32767});
    pending_samples.push_back('{16'd1, 15'sd12868, 16'sd32767, -16'sd32768});
    pending_samples.push_back('{16'd65535, 15'h4000, 16'sd32767, 16'sd32767});
    pending_samples.push_back('{16'd400, 15'sd16383, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'd400, 15'h4000, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'd1000, -15'sd1, 16'sd204, -16'sd204});
    pending_samples.push_back('{16'd5000, 15'sd1, 16'sd205, -16'sd205});
    pending_samples.push_back('{16'd5000, 15'sd1, 16'sd6145, -16'sd6145});
    random_phase(130);
    drain();

    // Extremes: full-scale gains and limits, no deadband.
    write_reg(REG_SAFE_DIST, 16'hFFFF);
    write_reg(REG_DANGER_DIST, 16'h0000);
    write_reg(REG_LINEAR_GAIN, 16'hFFFF);
    write_reg(REG_TURN_GAIN, 16'hFFFF);
    write_reg(REG_LINEAR_LIMIT, 16'h7FFF);
    write_reg(REG_LINEAR_DB, 16'h0000);
    write_reg(REG_ANGULAR_LIM, 16'h7FFF);
    write_reg(REG_ANGULAR_DB, 16'h0000);
    write_reg(4'd12, 16'h1234);
    pending_samples.push_back('{16'd0, 15'sd100, 16'sd0, 16'sd0});
    random_phase(120);
    drain();

    // Empty caution band, deadband above limit, zero gains.
    write_reg(REG_SAFE_DIST, 16'd500);
    write_reg(REG_DANGER_DIST, 16'hFFFF);
    write_reg(REG_LINEAR_GAIN, 16'h0000);
    write_reg(REG_TURN_GAIN, 16'h0000);
    write_reg(REG_LINEAR_LIMIT, 16'd100);
    write_reg(REG_LINEAR_DB, 16'h7FFF);
    write_reg(REG_ANGULAR_LIM, 16'h0000);
    write_reg(REG_ANGULAR_DB, 16'd50);
    random_phase(100);
    drain();

    // Random mid-range settings; last stretch has no idling.
    write_reg(REG_SAFE_DIST, 16'($urandom_range(2000, 20000)));
    write_reg(REG_DANGER_DIST, 16'($urandom_range(0, 2000)));
    write_reg(REG_LINEAR_GAIN, 16'($urandom));
    write_reg(REG_TURN_GAIN, 16'($urandom));
    write_reg(REG_LINEAR_LIMIT, 16'($urandom_range(1000, 32767)));
    write_reg(REG_LINEAR_DB, 16'($urandom_range(0, 500)));
    write_reg(REG_ANGULAR_LIM, 16'($urandom_range(1000, 32767)));
    write_reg(REG_ANGULAR_DB, 16'($urandom_range(0, 500)));
    random_phase(100);
    while (pending_samples.size() > 50) @(posedge clk);
    quiet = 1'b1;
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
